### hw/rtl/gaussian_elimination_solver_top_defines.svh
// assertion macros for the solver checker
`ifndef GAUSSIAN_ELIMINATION_SOLVER_TOP_DEFINES_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_TOP_DEFINES_SVH

// same-cycle implication
`define GES_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ges check failed");

// next-cycle implication
`define GES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ges check failed");

`endif

### hw/rtl/ges_pkg.sv
`default_nettype none
package ges_pkg;

  localparam int MAX_UNKNOWNS = 8;
  localparam int COLS         = MAX_UNKNOWNS + 1;
  localparam int STORE_DEPTH  = MAX_UNKNOWNS * COLS;
  localparam int ROW_W        = $clog2(MAX_UNKNOWNS);
  localparam int CNT_W        = $clog2(MAX_UNKNOWNS + 2);
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int POS_W        = $clog2(STORE_DEPTH + 1);
  localparam int DATA_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int DIV_W        = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS    = DIV_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int CFG_W        = 4;
  localparam int IDX_W        = 3;
  localparam int RESET_ROWS   = 8;
  localparam logic [DATA_W-1:0] ONE_Q16 = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    WR_RD   = 2'd0,
    WR_HOLD = 2'd1,
    WR_DIV  = 2'd2,
    WR_SUB  = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic             wr_en;
    wr_sel_e          wr_sel;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             ld_hold;
    logic             ld_pivot;
    logic             ld_factor;
    logic             ld_acc;
    logic             acc_sub;
    logic             div_start;
    logic             mul_en;
    logic             mul_bs;
    logic             sol_wr;
    logic             sol_rd;
    logic [ROW_W-1:0] sol_idx;
    logic             out_load;
    logic             out_sing;
    logic             out_last;
  } ges_cmd_t;

  typedef struct packed {
    logic             rd_zero;
    logic             rd_one;
    logic             div_done;
    logic             out_xfer;
    logic             out_last;
    logic [CNT_W-1:0] n;
  } ges_stat_t;

endpackage
`default_nettype wire

### hw/rtl/gaussian_elimination_solver_top.sv
// Solves an n-by-n linear system in signed Q16.16 (n = rows_in_use, 1..8, zero read as one).
// The augmented matrix is loaded row-major, one coefficient per cycle, into a 72-entry
// memory that needs no clearing pass; the entry flagged last_entry starts the solve, and
// no coefficient is taken until every result of that solve has been transferred. The solve
// is done by one sequencer over a single-port matrix memory: normalizing a pivot row divides
// each entry in one 48-step bit-serial divider, eliminating a lower row reads, multiplies and
// writes back each entry in turn, and back substitution follows; results then leave one at a
// time, each held until the sink takes it before the next is read. A singular system yields
// one result with singular set and last_result set.
`default_nettype none
module gaussian_elimination_solver_top
  import ges_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_W-1:0]         rows_in_use_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [DATA_W-1:0] coefficient_i,
  input  wire logic                     last_entry_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      solution_value_o,
  output logic [IDX_W-1:0]              unknown_index_o,
  output logic                          singular_o,
  output logic                          last_result_o
);

  ges_cmd_t  cmd;
  ges_stat_t stat;

  ges_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_entry_i (last_entry_i),
    .in_stall_o   (in_stall_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ges_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .coefficient_i    (coefficient_i),
    .last_entry_i     (last_entry_i),
    .cfg_we_i         (cfg_we_i),
    .rows_in_use_i    (rows_in_use_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .solution_value_o (solution_value_o),
    .unknown_index_o  (unknown_index_o),
    .singular_o       (singular_o),
    .last_result_o    (last_result_o)
  );

endmodule
`default_nettype wire

### hw/rtl/ges_div.sv
`default_nettype none
module ges_div
  import ges_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quot_o
);

  logic                 busy_q, fin_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dd_q;
  logic [DATA_W-1:0]    rem_q, dsor_q;
  logic [DATA_W:0]      rem_sh;
  logic                 ge;
  logic [DATA_W-1:0]    mag_a, mag_d;

  assign mag_a  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_d  = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign rem_sh = {rem_q, dd_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q   <= {mag_a, {FRAC_BITS{1'b0}}};
      dsor_q <= mag_d;
      rem_q  <= '0;
      neg_q  <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? DATA_W'(rem_sh - {1'b0, dsor_q}) : rem_sh[DATA_W-1:0];
      dd_q  <= {dd_q[DIV_W-2:0], ge};
    end
  end

  // saturate the magnitude back to signed q16.16
  always_comb begin
    if (!neg_q) begin
      if (|dd_q[DIV_W-1:DATA_W-1]) quot_o = {1'b0, {(DATA_W-1){1'b1}}};
      else                         quot_o = dd_q[DATA_W-1:0];
    end else begin
      if (dd_q > (DIV_W'(1) << (DATA_W-1))) quot_o = {1'b1, {(DATA_W-1){1'b0}}};
      else                                  quot_o = ~dd_q[DATA_W-1:0] + 1'b1;
    end
  end

  assign done_o = fin_q;

endmodule
`default_nettype wire

### hw/rtl/ges_dp.sv
`default_nettype none
module ges_dp
  import ges_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ges_cmd_t                 cmd_i,
  output ges_stat_t                     stat_o,
  input  wire logic signed [DATA_W-1:0] coefficient_i,
  input  wire logic                     last_entry_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_W-1:0]         rows_in_use_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      solution_value_o,
  output logic [IDX_W-1:0]              unknown_index_o,
  output logic                          singular_o,
  output logic                          last_result_o
);

  logic [DATA_W-1:0] mat_mem [STORE_DEPTH];
  logic [DATA_W-1:0] sol_mem [MAX_UNKNOWNS];

  logic [CFG_W-1:0]  rows_q;
  logic [POS_W-1:0]  pos_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] rd_q, hold_q, pivot_q, factor_q, acc_q, sol_rd_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] out_val_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_sing_q, out_last_q;

  logic [CNT_W-1:0]  n;
  logic [POS_W-1:0]  total;
  logic [ADDR_W-1:0] cell_addr;
  logic [DATA_W-1:0] mul_a, mul_b, wr_data, div_q, qm, minuend, sub_res;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [DATA_W:0]     diff;
  logic              div_done, out_xfer;

  always_comb begin
    if (rows_q == '0)                      n = CNT_W'(1);
    else if (int'(rows_q) > MAX_UNKNOWNS)  n = CNT_W'(MAX_UNKNOWNS);
    else                                   n = CNT_W'(rows_q);
  end

  assign total     = POS_W'(n) * POS_W'(n + 1'b1);
  assign cell_addr = ADDR_W'(cmd_i.row) * ADDR_W'(n + 1'b1) + ADDR_W'(cmd_i.col);

  // q16.16 product, truncated toward zero and saturated
  always_comb begin
    prod_sh = prod_q >>> FRAC_BITS;
    if (prod_q[2*DATA_W-1] && (|prod_q[FRAC_BITS-1:0])) prod_sh = prod_sh + 1'b1;
    if (prod_sh[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){prod_sh[2*DATA_W-1]}})
      qm = prod_sh[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      qm = prod_sh[DATA_W-1:0];
  end

  assign minuend = cmd_i.acc_sub ? acc_q : rd_q;
  assign diff    = signed'({minuend[DATA_W-1], minuend}) - signed'({qm[DATA_W-1], qm});

  always_comb begin
    if (diff[DATA_W] != diff[DATA_W-1])
      sub_res = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      sub_res = diff[DATA_W-1:0];
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_RD:   wr_data = rd_q;
      WR_HOLD: wr_data = hold_q;
      WR_DIV:  wr_data = div_q;
      WR_SUB:  wr_data = sub_res;
      default: wr_data = rd_q;
    endcase
  end

  assign mul_a = cmd_i.mul_bs ? rd_q : factor_q;
  assign mul_b = cmd_i.mul_bs ? sol_rd_q : rd_q;

  ges_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (pivot_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (pos_q < total)) begin
      mat_mem[pos_q[ADDR_W-1:0]] <= coefficient_i;
    end else if (cmd_i.wr_en) begin
      mat_mem[cell_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mat_mem[cell_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sol_wr) begin
      sol_mem[cmd_i.sol_idx] <= acc_q;
    end
    if (cmd_i.sol_rd) begin
      sol_rd_q <= sol_mem[cmd_i.sol_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_hold)   hold_q   <= rd_q;
    if (cmd_i.ld_pivot)  pivot_q  <= rd_q;
    if (cmd_i.ld_factor) factor_q <= rd_q;
    if (cmd_i.ld_acc)    acc_q    <= rd_q;
    else if (cmd_i.acc_sub) acc_q <= sub_res;
    if (cmd_i.mul_en)    prod_q   <= signed'(mul_a) * signed'(mul_b);
    if (cmd_i.out_load) begin
      out_val_q  <= cmd_i.out_sing ? '0 : sol_rd_q;
      out_idx_q  <= cmd_i.out_sing ? '0 : IDX_W'(cmd_i.sol_idx);
      out_sing_q <= cmd_i.out_sing;
      out_last_q <= cmd_i.out_sing | cmd_i.out_last;
    end
  end

  assign out_xfer = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= CFG_W'(RESET_ROWS);
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rows_q <= rows_in_use_i;
      if (cmd_i.load) begin
        if (last_entry_i)        pos_q <= '0;
        else if (pos_q < total)  pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (out_xfer)   out_valid_q <= 1'b0;
    end
  end

  assign stat_o.rd_zero  = (rd_q == '0);
  assign stat_o.rd_one   = (rd_q == ONE_Q16);
  assign stat_o.div_done = div_done;
  assign stat_o.out_xfer = out_xfer;
  assign stat_o.out_last = out_last_q;
  assign stat_o.n        = n;

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = out_val_q;
  assign unknown_index_o  = out_idx_q;
  assign singular_o       = out_sing_q;
  assign last_result_o    = out_last_q;

endmodule
`default_nettype wire

### hw/rtl/ges_ctrl.sv
`default_nettype none
module ges_ctrl
  import ges_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      last_entry_i,
  output logic           in_stall_o,
  input  wire ges_stat_t stat_i,
  output ges_cmd_t       cmd_o
);

  typedef enum logic [25:0] {
    S_IDLE      = 26'h0000001,
    S_ITOP      = 26'h0000002,
    S_PIV_CHK   = 26'h0000004,
    S_SRCH_TEST = 26'h0000008,
    S_SRCH_CHK  = 26'h0000010,
    S_SWP_RDA   = 26'h0000020,
    S_SWP_RDB   = 26'h0000040,
    S_SWP_WR    = 26'h0000080,
    S_SWP_WR2   = 26'h0000100,
    S_NORM_RD   = 26'h0000200,
    S_NORM_DIV  = 26'h0000400,
    S_NORM_WAIT = 26'h0000800,
    S_ELIM_NEXT = 26'h0001000,
    S_ELIM_FCHK = 26'h0002000,
    S_ELIM_RDP  = 26'h0004000,
    S_ELIM_MUL  = 26'h0008000,
    S_ELIM_WR   = 26'h0010000,
    S_BS_TOP    = 26'h0020000,
    S_BS_ACC    = 26'h0040000,
    S_BS_JT     = 26'h0080000,
    S_BS_MUL    = 26'h0100000,
    S_BS_SUB    = 26'h0200000,
    S_OUT_RD    = 26'h0400000,
    S_OUT_LD    = 26'h0800000,
    S_OUT_WAIT  = 26'h1000000,
    S_SING      = 26'h2000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, z_q, z_d;
  logic [CNT_W-1:0] n;

  assign n = stat_i.n;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    z_d     = z_q;
    cmd_o   = '0;
    cmd_o.wr_sel = WR_RD;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && last_entry_i) begin
          i_d     = '0;
          state_d = S_ITOP;
        end
      end
      S_ITOP: begin
        if (i_q < n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = i_q;
          cmd_o.col   = i_q;
          state_d     = S_PIV_CHK;
        end else begin
          state_d = S_BS_TOP;
        end
      end
      S_PIV_CHK: begin
        if (stat_i.rd_one) begin
          z_d     = i_q + 1'b1;
          state_d = S_ELIM_NEXT;
        end else if (stat_i.rd_zero) begin
          z_d     = i_q + 1'b1;
          state_d = S_SRCH_TEST;
        end else begin
          cmd_o.ld_pivot = 1'b1;
          j_d     = '0;
          state_d = S_NORM_RD;
        end
      end
      S_SRCH_TEST: begin
        if (z_q < n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = z_q;
          cmd_o.col   = i_q;
          state_d     = S_SRCH_CHK;
        end else begin
          state_d = S_SING;
        end
      end
      S_SRCH_CHK: begin
        if (!stat_i.rd_zero) begin
          j_d     = '0;
          state_d = S_SWP_RDA;
        end else begin
          z_d     = z_q + 1'b1;
          state_d = S_SRCH_TEST;
        end
      end
      S_SWP_RDA: begin
        if (j_q <= n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = i_q;
          cmd_o.col   = j_q;
          state_d     = S_SWP_RDB;
        end else begin
          state_d = S_ITOP;
        end
      end
      S_SWP_RDB: begin
        cmd_o.ld_hold = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.row     = z_q;
        cmd_o.col     = j_q;
        state_d       = S_SWP_WR;
      end
      S_SWP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_RD;
        cmd_o.row    = i_q;
        cmd_o.col    = j_q;
        state_d      = S_SWP_WR2;
      end
      S_SWP_WR2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_HOLD;
        cmd_o.row    = z_q;
        cmd_o.col    = j_q;
        j_d          = j_q + 1'b1;
        state_d      = S_SWP_RDA;
      end
      S_NORM_RD: begin
        if (j_q <= n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = i_q;
          cmd_o.col   = j_q;
          state_d     = S_NORM_DIV;
        end else begin
          z_d     = i_q + 1'b1;
          state_d = S_ELIM_NEXT;
        end
      end
      S_NORM_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_NORM_WAIT;
      end
      S_NORM_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_DIV;
          cmd_o.row    = i_q;
          cmd_o.col    = j_q;
          j_d          = j_q + 1'b1;
          state_d      = S_NORM_RD;
        end
      end
      S_ELIM_NEXT: begin
        if (z_q < n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = z_q;
          cmd_o.col   = i_q;
          state_d     = S_ELIM_FCHK;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_ITOP;
        end
      end
      S_ELIM_FCHK: begin
        if (!stat_i.rd_zero) begin
          cmd_o.ld_factor = 1'b1;
          j_d     = '0;
          state_d = S_ELIM_RDP;
        end else begin
          z_d     = z_q + 1'b1;
          state_d = S_ELIM_NEXT;
        end
      end
      S_ELIM_RDP: begin
        if (j_q <= n) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = i_q;
          cmd_o.col   = j_q;
          state_d     = S_ELIM_MUL;
        end else begin
          z_d     = z_q + 1'b1;
          state_d = S_ELIM_NEXT;
        end
      end
      S_ELIM_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.row    = z_q;
        cmd_o.col    = j_q;
        state_d      = S_ELIM_WR;
      end
      S_ELIM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SUB;
        cmd_o.row    = z_q;
        cmd_o.col    = j_q;
        j_d          = j_q + 1'b1;
        state_d      = S_ELIM_RDP;
      end
      S_BS_TOP: begin
        if (i_q != '0) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.row   = i_q - 1'b1;
          cmd_o.col   = n;
          i_d         = i_q - 1'b1;
          state_d     = S_BS_ACC;
        end else begin
          z_d     = '0;
          state_d = S_OUT_RD;
        end
      end
      S_BS_ACC: begin
        cmd_o.ld_acc = 1'b1;
        j_d          = n - 1'b1;
        state_d      = S_BS_JT;
      end
      S_BS_JT: begin
        if (j_q > i_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.row     = i_q;
          cmd_o.col     = j_q;
          cmd_o.sol_rd  = 1'b1;
          cmd_o.sol_idx = ROW_W'(j_q);
          state_d       = S_BS_MUL;
        end else begin
          cmd_o.sol_wr  = 1'b1;
          cmd_o.sol_idx = ROW_W'(i_q);
          state_d       = S_BS_TOP;
        end
      end
      S_BS_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_bs = 1'b1;
        state_d      = S_BS_SUB;
      end
      S_BS_SUB: begin
        cmd_o.acc_sub = 1'b1;
        j_d           = j_q - 1'b1;
        state_d       = S_BS_JT;
      end
      S_OUT_RD: begin
        cmd_o.sol_rd  = 1'b1;
        cmd_o.sol_idx = ROW_W'(z_q);
        state_d       = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.sol_idx  = ROW_W'(z_q);
        cmd_o.out_last = ((z_q + 1'b1) == n);
        state_d        = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (stat_i.out_xfer) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            z_d     = z_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      S_SING: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_sing = 1'b1;
        state_d        = S_OUT_WAIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      z_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      z_q     <= z_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

### hw/rtl/ges_chk.sv
`default_nettype none
`include "gaussian_elimination_solver_top_defines.svh"
module ges_chk
  import ges_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     last_entry_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic signed [DATA_W-1:0] solution_value_o,
  input wire logic [IDX_W-1:0]         unknown_index_o,
  input wire logic                     singular_o,
  input wire logic                     last_result_o
);

  logic sing_ok;

  assign sing_ok = last_result_o && (solution_value_o == '0) && (unknown_index_o == '0);

  // held result stays offered
  `GES_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // singular result is a lone zero at index zero
  `GES_ASSERT_SAME(a_sing_form, out_valid_o && singular_o, sing_ok)
  // the closing transfer starts a solve and blocks loading
  `GES_ASSERT_NEXT(a_solve_start, in_valid_i && !in_stall_o && last_entry_i, in_stall_o)
  // no loading while a result is offered
  `GES_ASSERT_SAME(a_no_load_out, out_valid_o, in_stall_o)

endmodule

bind gaussian_elimination_solver_top ges_chk u_chk (.*);
`default_nettype wire
